/* sv/bffa_pkg.sv */
`default_nettype none
package bffa_pkg;

  localparam int WORD_BITS   = 32;
  localparam int MAX_ENTRIES = 1024;
  localparam int NUM_WORDS   = MAX_ENTRIES / WORD_BITS;
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int WORD_AW     = $clog2(NUM_WORDS);
  localparam int IDX_W       = 10;
  localparam int CAP_W       = 11;
  localparam int STATUS_W    = 2;
  localparam int WLIM_W      = WORD_AW + 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 2'd2;

  // write-back info from the update stage to the word tracker
  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] word;
    logic               full;
  } word_upd_t;

  // position of the lowest set bit, zero when none
  function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_AW-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = i[BIT_AW-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/bitmap_first_fit_allocator_unit.sv */
`default_nettype none
// first-fit bitmap allocator over 1024 entries kept as 32 words of 32 bits
// input channel (s_*): s_tuser is the command (0 allocate, 1 release),
//   s_tdata carries the entry to release; it is ignored on allocate
// output channel (m_*): one transaction per input, granted index and status
//   (0 ok, 1 no free entry, 2 release of a free or out-of-range entry)
// cfg_we/cfg_wdata write the capacity; only whole words below it are
//   searched, and values above 1024 act as 1024
// each request runs in two steps: the accept cycle picks the word from the
//   per-word full flags and reads it from the bitmap memory; the update stage,
//   entered in the cycle after accept, finds the bit and, once the output
//   register is free, writes the word back and loads the output register
// the read-modify-write of one bitmap word bounds the request rate; a new
//   request is taken only after the write-back, so accesses never overlap
// reset clears capacity to 1024, the full flags and the per-word written
//   marks; an unwritten word reads as all free, so no clearing pass is needed
// a stalled receiver holds the result in the output register; the next
//   request may still be accepted and then waits in the update stage
module bitmap_first_fit_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,      // capacity
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,        // [9:0] entry_index, [15:10] zero
  input  wire logic        s_tuser,        // [0] command
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0] m_tdata              // [9:0] granted_index, [11:10] status, [15:12] zero
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MOD  = 1'b1;

  logic                              state;
  logic [bffa_pkg::CAP_W-1:0]        capacity;

  // request held from the accept cycle for the update stage
  logic                              cmd_r;
  logic [bffa_pkg::IDX_W-1:0]        idx_r;
  logic [bffa_pkg::WORD_AW-1:0]      word_r;
  logic                              hit_r;
  logic                              in_range_r;
  logic                              valid_r;

  logic [bffa_pkg::IDX_W-1:0]        granted;
  logic [bffa_pkg::STATUS_W-1:0]     status;

  logic                              accept;
  logic                              out_free;
  logic                              finish;
  logic [bffa_pkg::WLIM_W-1:0]       word_limit;
  logic [bffa_pkg::WORD_AW-1:0]      pick_word;
  logic                              pick_hit;
  logic [bffa_pkg::WORD_AW-1:0]      rd_word;
  logic                              rd_valid;
  logic [bffa_pkg::IDX_W-1:0]        in_idx;

  logic [bffa_pkg::WORD_BITS-1:0]    ram_rdata;
  logic [bffa_pkg::WORD_BITS-1:0]    word_data;
  logic [bffa_pkg::WORD_BITS-1:0]    new_word;
  logic [bffa_pkg::BIT_AW-1:0]       bit_sel;
  logic                              do_write;
  logic [bffa_pkg::IDX_W-1:0]        res_index;
  logic [bffa_pkg::STATUS_W-1:0]     res_status;
  bffa_pkg::word_upd_t               upd;

  assign in_idx   = s_tdata[bffa_pkg::IDX_W-1:0];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_MOD) && out_free;

  // number of whole words below capacity, saturated at the full map
  assign word_limit = (capacity >= bffa_pkg::CAP_RESET) ?
                      bffa_pkg::WLIM_W'(bffa_pkg::NUM_WORDS) :
                      {1'b0, capacity[bffa_pkg::BIT_AW +: bffa_pkg::WORD_AW]};

  // word to read: first non-full word on allocate, the entry's word on release
  assign rd_word = (s_tuser == bffa_pkg::CMD_RELEASE) ?
                   in_idx[bffa_pkg::IDX_W-1 -: bffa_pkg::WORD_AW] : pick_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bffa_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= s_tuser;
      idx_r      <= in_idx;
      word_r     <= rd_word;
      hit_r      <= pick_hit;
      in_range_r <= ({1'b0, in_idx} < capacity);
      valid_r    <= rd_valid;
    end
  end

  bffa_word_track u_track (
    .clk        (clk),
    .rst        (rst),
    .word_limit (word_limit),
    .upd        (upd),
    .rd_word    (rd_word),
    .rd_valid   (rd_valid),
    .pick_word  (pick_word),
    .pick_hit   (pick_hit)
  );

  bffa_ram #(
    .DEPTH (bffa_pkg::NUM_WORDS),
    .WIDTH (bffa_pkg::WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (word_r),
    .wdata (new_word),
    .re    (accept),
    .raddr (rd_word),
    .rdata (ram_rdata)
  );

  // update stage: never-written words read as all free
  assign word_data = valid_r ? ram_rdata : '0;

  always_comb begin
    res_index  = '0;
    res_status = bffa_pkg::STATUS_FULL;
    new_word   = word_data;
    bit_sel    = idx_r[bffa_pkg::BIT_AW-1:0];
    do_write   = 1'b0;
    if (cmd_r == bffa_pkg::CMD_ALLOC) begin
      bit_sel = bffa_pkg::lowest_set(~word_data);
      if (hit_r) begin
        new_word   = word_data | (bffa_pkg::WORD_BITS'(1) << bit_sel);
        res_index  = {word_r, bit_sel};
        res_status = bffa_pkg::STATUS_OK;
        do_write   = finish;
      end
    end else begin
      res_status = bffa_pkg::STATUS_BAD_RELEASE;
      if (in_range_r && word_data[bit_sel]) begin
        new_word   = word_data & ~(bffa_pkg::WORD_BITS'(1) << bit_sel);
        res_index  = idx_r;
        res_status = bffa_pkg::STATUS_OK;
        do_write   = finish;
      end
    end
  end

  // en, word, full
  assign upd = {do_write, word_r, &new_word};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      granted <= res_index;
      status  <= res_status;
    end
  end

  assign m_tdata = {4'b0, status, granted};

  // checks
  ap_accept_to_mod: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_MOD))
    else $error("request not moved to update stage");

  ap_no_read_in_mod: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> !accept)
    else $error("bitmap read while update pending");

  ap_write_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    do_write |-> (finish && res_status == bffa_pkg::STATUS_OK))
    else $error("bitmap written without ok result");

  ap_err_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != bffa_pkg::STATUS_OK) |-> (granted == '0))
    else $error("nonzero index on error status");

  ap_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    finish |=> m_tvalid)
    else $error("result lost from output register");

endmodule
`default_nettype wire

/* sv/bffa_ram.sv */
`default_nettype none
module bffa_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/bffa_word_track.sv */
`default_nettype none
module bffa_word_track (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [bffa_pkg::WLIM_W-1:0]      word_limit,
  input  wire bffa_pkg::word_upd_t              upd,
  input  wire logic [bffa_pkg::WORD_AW-1:0]     rd_word,
  output logic                                  rd_valid,
  output logic [bffa_pkg::WORD_AW-1:0]          pick_word,
  output logic                                  pick_hit
);

  logic [bffa_pkg::NUM_WORDS-1:0] full_flags;
  logic [bffa_pkg::NUM_WORDS-1:0] word_valid;
  logic [bffa_pkg::NUM_WORDS-1:0] cand;

  // full flags and written marks, cleared at reset in place of the bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      full_flags <= '0;
      word_valid <= '0;
    end else if (upd.en) begin
      full_flags[upd.word] <= upd.full;
      word_valid[upd.word] <= 1'b1;
    end
  end

  always_comb begin
    for (int w = 0; w < bffa_pkg::NUM_WORDS; w++) begin
      cand[w] = !full_flags[w] && (bffa_pkg::WLIM_W'(w) < word_limit);
    end
  end

  assign pick_hit  = |cand;
  assign pick_word = bffa_pkg::lowest_set(cand);
  assign rd_valid  = word_valid[rd_word];

endmodule
`default_nettype wire
